@@ rtl/core/pbrf_pkg.sv @@
// Shared constants, codes and types of the packet blocklist and rate filter.
package pbrf_pkg;

  // Table geometry.
  localparam int unsigned TABLE_ENTRIES = 256;
  localparam int unsigned IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int unsigned CNT_W         = IDX_W + 1;

  // Header checks.
  localparam logic [15:0] DEFAULT_PORT    = 16'd2049;
  localparam logic [15:0] MIN_FRAME_BYTES = 16'd54;
  localparam logic [15:0] ETHTYPE_IPV4    = 16'h0800;
  localparam logic [7:0]  PROTO_TCP       = 8'd6;

  // Rate gap is one second divided by the slot limit; the quotient fits 30 bits.
  localparam int unsigned QUOT_W     = 30;
  localparam int unsigned DIV_CNT_W  = $clog2(QUOT_W);
  localparam logic [QUOT_W-1:0] NS_PER_SEC = 30'd1000000000;

  // Stream word layout.
  localparam int unsigned IN_DATA_W  = 224;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 8;
  localparam int unsigned OUT_USER_W = 3;

  typedef enum logic [1:0] {
    CMD_PKT   = 2'd0,
    CMD_WR_BL = 2'd1,
    CMD_WR_RT = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    CAUSE_NONE  = 2'd0,
    CAUSE_BLOCK = 2'd1,
    CAUSE_RATE  = 2'd2
  } cause_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BL_SCAN,
    ST_RT_SCAN,
    ST_DIV,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic        start;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quot;
  } div_rsp_t;

endpackage

@@ rtl/core/pbrf_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module pbrf_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ rtl/core/pbrf_div.sv @@
// Bit-serial restoring divider: one second in ns divided by a 32-bit rate limit.
module pbrf_div
  import pbrf_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [QUOT_W-1:0]    rem_q, rem_d;
  logic [QUOT_W-1:0]    quot_q, quot_d;
  logic [31:0]          div_q, div_d;
  logic [QUOT_W:0]      trial;
  logic                 fits;

  // Bring down the next dividend bit and try the subtraction.
  assign trial = {rem_q, NS_PER_SEC[cnt_q]};
  assign fits  = 32'(trial) >= div_q;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quot_d = quot_q;
    div_d  = div_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(QUOT_W - 1);
      rem_d  = '0;
      div_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d  = fits ? QUOT_W'(32'(trial) - div_q) : trial[QUOT_W-1:0];
      quot_d = {quot_q[QUOT_W-2:0], fits};
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    div_q  <= div_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

@@ rtl/core/packet_blocklist_rate_filter_core.sv @@
// Top level of the packet blocklist and per-source rate filter.
//
//   Channel   Dir  Handshake            Word contents
//   s_*       in   s_tvalid/s_tready    tuser: cmd; tdata: header fields or table write
//   m_*       out  m_tvalid/m_tready    tuser: drop, drop_cause; tdata: hit_index
//   cfg_*     in   cfg_we_i (no wait)   service_port
//
// Flow: write words and words that skip inspection go straight to the response. An
// inspected packet walks the blocklist RAM then the rate RAMs, one slot read per cycle
// while the divider is idle, until a slot drops it; each enabled rate slot matching the
// source waits for its gap 1e9/limit from the bit-serial divider before the walk resumes.
// Reset: a clearing pass zeroes every slot of all tables; s_tready stays low meanwhile,
// configuration writes are taken.
// Stalls: one word is in work at a time; a finished result waits in the output
// register while the next word is accepted and processed.
module packet_blocklist_rate_filter_core
  import pbrf_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // tuser: cmd[1:0]
  // tdata: frame_len[15:0], ether_type[31:16], ip_protocol[39:32], dest_port[55:40],
  //        source_ip[87:56], now_ns[151:88], entry_index[159:152],
  //        entry_ip[191:160], entry_limit[223:192]
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic [IN_USER_W-1:0]  s_tuser,
  // tuser: drop[0], drop_cause[2:1]
  // tdata: hit_index[7:0]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic [OUT_USER_W-1:0] m_tuser,
  input  logic                  cfg_we_i,
  input  logic [15:0]           cfg_wdata_i
);

  // Input word fields.
  logic [15:0] in_frame_len, in_ether_type, in_dest_port;
  logic [7:0]  in_ip_protocol, in_entry_index;
  logic [31:0] in_source_ip, in_entry_ip, in_entry_limit;
  logic [63:0] in_now_ns;

  assign in_frame_len   = s_tdata[15:0];
  assign in_ether_type  = s_tdata[31:16];
  assign in_ip_protocol = s_tdata[39:32];
  assign in_dest_port   = s_tdata[55:40];
  assign in_source_ip   = s_tdata[87:56];
  assign in_now_ns      = s_tdata[151:88];
  assign in_entry_index = s_tdata[159:152];
  assign in_entry_ip    = s_tdata[191:160];
  assign in_entry_limit = s_tdata[223:192];

  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [CNT_W-1:0] LAST_CNT  = CNT_W'(TABLE_ENTRIES - 1);
  localparam logic [CNT_W-1:0] ENTRY_CNT = CNT_W'(TABLE_ENTRIES);

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   issue_q, issue_d;     // next slot to read, also clear pointer
  logic               rd_vld_q, rd_vld_d;   // RAM read data belongs to rd_idx_q
  logic [IDX_W-1:0]   rd_idx_q, rd_idx_d;
  logic [15:0]        svc_q;
  logic [31:0]        src_q, src_d;
  logic [63:0]        now_q, now_d;
  logic [63:0]        last_q, last_d;
  logic               res_drop_q, res_drop_d;
  cause_e             res_cause_q, res_cause_d;
  logic [7:0]         res_hit_q, res_hit_d;
  logic               m_valid_q, m_valid_d;
  logic [OUT_DATA_W-1:0] m_data_q, m_data_d;
  logic [OUT_USER_W-1:0] m_user_q, m_user_d;

  // RAM ports.
  logic              bl_we, rt_we, ls_we;
  logic [IDX_W-1:0]  bl_waddr, rt_waddr, ls_waddr;
  logic [31:0]       bl_wdata, bl_rdata;
  logic [63:0]       rt_wdata, rt_rdata;   // {limit, addr}
  logic [63:0]       ls_wdata, ls_rdata;
  logic [IDX_W-1:0]  raddr;

  div_req_t          div_req;
  div_rsp_t          div_rsp;

  logic              inspect;
  logic              index_ok;
  logic [63:0]       since_last;

  assign raddr      = issue_q[IDX_W-1:0];
  assign index_ok   = 32'(in_entry_index) < TABLE_ENTRIES;
  assign since_last = now_q - last_q;

  // Only IPv4/TCP frames of full header length aimed at the service port.
  assign inspect = (in_frame_len >= MIN_FRAME_BYTES) && (in_ether_type == ETHTYPE_IPV4)
                && (in_ip_protocol == PROTO_TCP) && (in_dest_port == svc_q);

  assign s_tready = (state_q == ST_IDLE);

  always_comb begin
    state_d     = state_q;
    issue_d     = issue_q;
    rd_vld_d    = 1'b0;
    rd_idx_d    = rd_idx_q;
    src_d       = src_q;
    now_d       = now_q;
    last_d      = last_q;
    res_drop_d  = res_drop_q;
    res_cause_d = res_cause_q;
    res_hit_d   = res_hit_q;
    bl_we       = 1'b0;
    rt_we       = 1'b0;
    ls_we       = 1'b0;
    bl_waddr    = issue_q[IDX_W-1:0];
    rt_waddr    = issue_q[IDX_W-1:0];
    ls_waddr    = issue_q[IDX_W-1:0];
    bl_wdata    = '0;
    rt_wdata    = '0;
    ls_wdata    = '0;
    div_req.start   = 1'b0;
    div_req.divisor = rt_rdata[63:32];

    // Output register: drop the word once taken.
    m_valid_d = m_valid_q && !m_tready;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;

    unique case (state_q)
      ST_CLEAR: begin
        // Zero one slot of every table per cycle.
        bl_we   = 1'b1;
        rt_we   = 1'b1;
        ls_we   = 1'b1;
        issue_d = issue_q + 1'b1;
        if (issue_q == LAST_CNT) begin
          issue_d = '0;
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (s_tvalid) begin
          src_d       = in_source_ip;
          now_d       = in_now_ns;
          res_drop_d  = 1'b0;
          res_cause_d = CAUSE_NONE;
          res_hit_d   = '0;
          issue_d     = '0;
          state_d     = ST_RESP;
          unique case (s_tuser)
            CMD_PKT: begin
              if (inspect) begin
                state_d = ST_BL_SCAN;
              end
            end
            CMD_WR_BL: begin
              bl_we    = index_ok;
              bl_waddr = IDX_W'(in_entry_index);
              bl_wdata = in_entry_ip;
            end
            CMD_WR_RT: begin
              rt_we    = index_ok;
              rt_waddr = IDX_W'(in_entry_index);
              rt_wdata = {in_entry_limit, in_entry_ip};
            end
            default: begin
              // Unused command: answer with a pass.
            end
          endcase
        end
      end

      ST_BL_SCAN: begin
        if (issue_q < ENTRY_CNT) begin
          rd_vld_d = 1'b1;
          rd_idx_d = issue_q[IDX_W-1:0];
          issue_d  = issue_q + 1'b1;
        end
        if (rd_vld_q) begin
          if (bl_rdata == src_q) begin
            res_drop_d  = 1'b1;
            res_cause_d = CAUSE_BLOCK;
            res_hit_d   = 8'(rd_idx_q);
            state_d     = ST_RESP;
          end else if (rd_idx_q == LAST_IDX) begin
            rd_vld_d = 1'b0;
            issue_d  = '0;
            state_d  = ST_RT_SCAN;
          end
        end
      end

      ST_RT_SCAN: begin
        if (issue_q < ENTRY_CNT) begin
          rd_vld_d = 1'b1;
          rd_idx_d = issue_q[IDX_W-1:0];
          issue_d  = issue_q + 1'b1;
        end
        if (rd_vld_q) begin
          if (rt_rdata[31:0] == src_q && rt_rdata[63:32] != '0) begin
            // Slot takes part: compute its gap, replay the reads after it.
            div_req.start = 1'b1;
            last_d        = ls_rdata;
            rd_vld_d      = 1'b0;
            rd_idx_d      = rd_idx_q;
            issue_d       = CNT_W'(rd_idx_q) + 1'b1;
            state_d       = ST_DIV;
          end else if (rd_idx_q == LAST_IDX) begin
            state_d = ST_RESP;
          end
        end
      end

      ST_DIV: begin
        if (div_rsp.done) begin
          if (since_last < 64'(div_rsp.quot)) begin
            res_drop_d  = 1'b1;
            res_cause_d = CAUSE_RATE;
            res_hit_d   = 8'(rd_idx_q);
            state_d     = ST_RESP;
          end else begin
            // Within limit: refresh the timestamp and go on.
            ls_we    = 1'b1;
            ls_waddr = rd_idx_q;
            ls_wdata = now_q;
            state_d  = (rd_idx_q == LAST_IDX) ? ST_RESP : ST_RT_SCAN;
          end
        end
      end

      ST_RESP: begin
        if (!m_valid_q || m_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = res_hit_q;
          m_user_d  = {res_cause_q, res_drop_q};
          state_d   = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      issue_q   <= '0;
      rd_vld_q  <= 1'b0;
      m_valid_q <= 1'b0;
      svc_q     <= DEFAULT_PORT;
    end else begin
      state_q   <= state_d;
      issue_q   <= issue_d;
      rd_vld_q  <= rd_vld_d;
      m_valid_q <= m_valid_d;
      if (cfg_we_i) begin
        svc_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q    <= rd_idx_d;
    src_q       <= src_d;
    now_q       <= now_d;
    last_q      <= last_d;
    res_drop_q  <= res_drop_d;
    res_cause_q <= res_cause_d;
    res_hit_q   <= res_hit_d;
    m_data_q    <= m_data_d;
    m_user_q    <= m_user_d;
  end

  assign m_tvalid = m_valid_q;
  assign m_tdata  = m_data_q;
  assign m_tuser  = m_user_q;

  // Blocklist addresses.
  pbrf_ram #(.WIDTH(32), .DEPTH(TABLE_ENTRIES)) u_bl_ram (
    .clk_i   (clk_i),
    .we_i    (bl_we),
    .waddr_i (bl_waddr),
    .wdata_i (bl_wdata),
    .raddr_i (raddr),
    .rdata_o (bl_rdata)
  );

  // Rate slots: limit in the upper half, address in the lower half.
  pbrf_ram #(.WIDTH(64), .DEPTH(TABLE_ENTRIES)) u_rt_ram (
    .clk_i   (clk_i),
    .we_i    (rt_we),
    .waddr_i (rt_waddr),
    .wdata_i (rt_wdata),
    .raddr_i (raddr),
    .rdata_o (rt_rdata)
  );

  // Last-seen timestamps of the rate slots.
  pbrf_ram #(.WIDTH(64), .DEPTH(TABLE_ENTRIES)) u_ls_ram (
    .clk_i   (clk_i),
    .we_i    (ls_we),
    .waddr_i (ls_waddr),
    .wdata_i (ls_wdata),
    .raddr_i (raddr),
    .rdata_o (ls_rdata)
  );

  pbrf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

endmodule

@@ rtl/core/pbrf_checker.sv @@
// Port-level checks of the filter core and their binding to it.
module pbrf_checker
  import pbrf_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic [OUT_USER_W-1:0] m_tuser
);

  // A dropped word always names a cause.
  a_drop_has_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && m_tuser[0] |->
      (m_tuser[2:1] == CAUSE_BLOCK || m_tuser[2:1] == CAUSE_RATE))
    else $error("drop without cause");

  // A passed word carries no cause and no slot.
  a_pass_is_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tuser[0] |-> m_tuser[2:1] == CAUSE_NONE && m_tdata == '0)
    else $error("pass with cause or slot");

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // One word in work at a time.
  a_one_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second word accepted while busy");

endmodule

bind packet_blocklist_rate_filter_core pbrf_checker u_pbrf_checker (.*);

@@ test/tb_packet_blocklist_rate_filter_core.sv @@
// Self-checking testbench for the packet blocklist and per-source rate filter core.
module tb_packet_blocklist_rate_filter_core;
  import pbrf_pkg::*;

  localparam logic [63:0] NS_IN_SEC = 64'd1000000000;
  localparam logic [63:0] START_NS  = 64'd5000000000;

  // One input word as the filter sees it.
  typedef struct packed {
    cmd_e        cmd;
    logic [15:0] flen;
    logic [15:0] ether;
    logic [7:0]  proto;
    logic [15:0] dport;
    logic [31:0] src;
    logic [63:0] now;
    logic [7:0]  idx;
    logic [31:0] eip;
    logic [31:0] elim;
  } filter_word_t;

  typedef struct packed {
    logic        drop;
    cause_e      cause;
    logic [7:0]  hit;
  } verdict_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  s_tvalid    = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata     = '0;
  logic [IN_USER_W-1:0]  s_tuser     = '0;
  logic                  m_tvalid;
  logic                  m_tready    = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [OUT_USER_W-1:0] m_tuser;
  logic                  cfg_we_i    = 1'b0;
  logic [15:0]           cfg_wdata_i = '0;

  packet_blocklist_rate_filter_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Shadow copy of the filter state.
  logic [15:0] port_model = DEFAULT_PORT;
  logic [31:0] bl_addr  [TABLE_ENTRIES];
  logic [31:0] rt_addr  [TABLE_ENTRIES];
  logic [31:0] rt_limit [TABLE_ENTRIES];
  logic [63:0] last_ns  [TABLE_ENTRIES];

  filter_word_t pending_words [$];
  verdict_t     verdicts_due  [$];
  filter_word_t word_on_bus;
  int           words_sent = 0;
  int           mismatches = 0;
  int           tx_idle    = 0;
  int           rx_idle    = 0;
  bit           calm       = 1'b0;
  bit           rx_hold    = 1'b0;

  logic [31:0] hosts [8];
  logic [63:0] gen_clock;

  initial begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      bl_addr[i]  = '0;
      rt_addr[i]  = '0;
      rt_limit[i] = '0;
      last_ns[i]  = '0;
    end
  end

  // Apply one word to the shadow tables and return the verdict it earns.
  function automatic verdict_t judge_word(input filter_word_t w);
    verdict_t    v;
    logic [63:0] gap;
    v.drop  = 1'b0;
    v.cause = CAUSE_NONE;
    v.hit   = '0;
    case (w.cmd)
      CMD_WR_BL: bl_addr[w.idx] = w.eip;
      CMD_WR_RT: begin
        rt_addr[w.idx]  = w.eip;
        rt_limit[w.idx] = w.elim;
      end
      CMD_PKT: begin
        if (w.flen >= MIN_FRAME_BYTES && w.ether == ETHTYPE_IPV4 &&
            w.proto == PROTO_TCP && w.dport == port_model) begin
          for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (bl_addr[i] == w.src) begin
              v.drop  = 1'b1;
              v.cause = CAUSE_BLOCK;
              v.hit   = 8'(i);
              return v;
            end
          end
          // Walk every matching enabled rate slot; the first one too early drops.
          for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (rt_addr[i] == w.src && rt_limit[i] != 0) begin
              gap = NS_IN_SEC / {32'd0, rt_limit[i]};
              if (w.now - last_ns[i] < gap) begin
                v.drop  = 1'b1;
                v.cause = CAUSE_RATE;
                v.hit   = 8'(i);
                return v;
              end
              last_ns[i] = w.now;
            end
          end
        end
      end
      default: ;
    endcase
    return v;
  endfunction

  function automatic filter_word_t noise_word();
    filter_word_t w;
    w.cmd   = cmd_e'($urandom_range(0, 2));
    w.flen  = 16'($urandom);
    w.ether = 16'($urandom);
    w.proto = 8'($urandom);
    w.dport = 16'($urandom);
    w.src   = $urandom;
    w.now   = {$urandom, $urandom};
    w.idx   = 8'($urandom);
    w.eip   = $urandom;
    w.elim  = $urandom;
    return w;
  endfunction

  // Well-formed TCP header aimed at the current service port.
  function automatic filter_word_t packet_to(input logic [31:0] src, input logic [63:0] t);
    filter_word_t w;
    w       = noise_word();
    w.cmd   = CMD_PKT;
    w.flen  = ($urandom_range(0, 3) == 0) ? MIN_FRAME_BYTES : 16'($urandom_range(54, 65535));
    w.ether = ETHTYPE_IPV4;
    w.proto = PROTO_TCP;
    w.dport = port_model;
    w.src   = src;
    w.now   = t;
    return w;
  endfunction

  function automatic filter_word_t table_write(input cmd_e c, input logic [7:0] idx,
                                               input logic [31:0] ip, input logic [31:0] lim);
    filter_word_t w;
    w      = noise_word();
    w.cmd  = c;
    w.idx  = idx;
    w.eip  = ip;
    w.elim = lim;
    return w;
  endfunction

  function automatic logic [31:0] pick_limit();
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      1:       return 32'd1;
      2:       return 32'd2;
      3:       return $urandom_range(3, 100);
      4:       return 32'd1000;
      5:       return 32'd1000000;
      6:       return 32'd1000000000;
      7:       return 32'd1000000001;
      8:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Mostly well-formed traffic from a small host pool, so rate slots really fire.
  function automatic filter_word_t random_word();
    filter_word_t w;
    logic [7:0]   idx;
    logic [31:0]  src;
    int           pick;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      // Churn low blocklist slots, mostly with random addresses and at times with hosts; scatter random slots too.
      if ($urandom_range(0, 3) == 0) begin
        idx = 8'($urandom);
        src = $urandom;
      end else begin
        idx = 8'($urandom_range(0, 7));
        src = ($urandom_range(0, 5) == 0) ? hosts[$urandom_range(0, 7)] : $urandom;
      end
      w = table_write(CMD_WR_BL, idx, src, $urandom);
    end else if (pick < 30) begin
      idx = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
      src = ($urandom_range(0, 4) == 0) ? $urandom : hosts[$urandom_range(0, 7)];
      w = table_write(CMD_WR_RT, idx, src, pick_limit());
    end else if (pick < 35) begin
      w = noise_word();
    end else begin
      case ($urandom_range(0, 3))
        0:       gen_clock = gen_clock + $urandom_range(0, 1000);
        1:       gen_clock = gen_clock + $urandom_range(0, 2000000);
        2:       gen_clock = gen_clock + $urandom_range(0, 200000000);
        default: gen_clock = gen_clock + $urandom_range(0, 2000000000);
      endcase
      if ($urandom_range(0, 99) == 0) gen_clock = {$urandom, $urandom};
      case ($urandom_range(0, 49))
        0:       src = '0;
        1, 2, 3: src = $urandom;
        default: src = hosts[$urandom_range(0, 7)];
      endcase
      w = packet_to(src, gen_clock);
      // Occasionally step back in time so the gap wraps around.
      if ($urandom_range(0, 49) == 0) w.now = gen_clock - $urandom_range(1, 5000);
      if (pick < 45) begin
        case ($urandom_range(0, 3))
          0:       w.flen  = 16'($urandom_range(0, 53));
          1:       w.ether = 16'($urandom);
          2:       w.proto = 8'($urandom);
          default: w.dport = port_model + 16'($urandom_range(1, 65535));
        endcase
      end
    end
    return w;
  endfunction

  // Driver: present queued words, idle in short random bursts.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        verdicts_due.push_back(judge_word(word_on_bus));
        words_sent++;
        if (!calm && $urandom_range(0, 3) == 0) tx_idle = $urandom_range(1, 7);
      end
      if (!s_tvalid || s_tready) begin
        if (tx_idle != 0) begin
          tx_idle--;
          s_tvalid <= 1'b0;
        end else if (pending_words.size() != 0) begin
          word_on_bus = pending_words.pop_front();
          s_tvalid <= 1'b1;
          s_tuser  <= word_on_bus.cmd;
          s_tdata  <= {word_on_bus.elim, word_on_bus.eip, word_on_bus.idx, word_on_bus.now,
                       word_on_bus.src, word_on_bus.dport, word_on_bus.proto,
                       word_on_bus.ether, word_on_bus.flen};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string field, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      $error("%s: expected %0d, got %0d", field, want, got);
    end
  endtask

  verdict_t verdict_want;

  // Monitor: take result words, compare against the oldest expected verdict.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (verdicts_due.size() == 0) begin
          mismatches++;
          $error("result word with no verdict pending: tuser %0h tdata %0h", m_tuser, m_tdata);
        end else begin
          verdict_want = verdicts_due.pop_front();
          check_field("drop", {7'd0, verdict_want.drop}, {7'd0, m_tuser[0]});
          check_field("drop_cause", {6'd0, verdict_want.cause}, {6'd0, m_tuser[2:1]});
          check_field("hit_index", verdict_want.hit, m_tdata[7:0]);
        end
      end
      if (rx_hold) begin
        m_tready <= 1'b0;
      end else if (rx_idle != 0) begin
        rx_idle--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (!calm && $urandom_range(0, 4) == 0) rx_idle = $urandom_range(1, 7);
      end
    end
  end

  // Long receiver hold-off while words keep coming, so the input stalls.
  initial begin : rx_holdoff
    wait (words_sent >= 150);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (3000) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  task automatic drain_all();
    wait (pending_words.size() == 0);
    @(posedge clk_i);
    while (s_tvalid || verdicts_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_port(input logic [15:0] p);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= p;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    port_model = p;
  endtask

  initial begin : stimulus
    logic [15:0]  ports [4];
    filter_word_t w;
    for (int k = 0; k < 8; k++) begin
      hosts[k] = $urandom;
      if (hosts[k] == 0) hosts[k] = 32'h0A00_0001;
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: cleared tables block source 0 at slot 0.
    pending_words.push_back(packet_to(32'd0, 64'd100));
    // Header checks around the inspection boundary.
    w = packet_to(hosts[0], 64'd200); w.flen = 16'd53;           pending_words.push_back(w);
    w = packet_to(hosts[0], 64'd300); w.flen = 16'd0;            pending_words.push_back(w);
    w = packet_to(hosts[0], 64'd400); w.flen = 16'hFFFF;         pending_words.push_back(w);
    w = packet_to(hosts[0], 64'd500); w.ether = 16'h86DD;        pending_words.push_back(w);
    w = packet_to(hosts[0], 64'd600); w.proto = 8'd17;           pending_words.push_back(w);
    w = packet_to(hosts[0], 64'd700); w.dport = DEFAULT_PORT - 1; pending_words.push_back(w);
    // Blocklist hits at the top and bottom slots.
    pending_words.push_back(table_write(CMD_WR_BL, 8'd255, hosts[0], 32'hFFFF_FFFF));
    pending_words.push_back(packet_to(hosts[0], 64'd800));
    pending_words.push_back(table_write(CMD_WR_BL, 8'd0, hosts[0], 32'd0));
    pending_words.push_back(packet_to(hosts[0], 64'd900));
    // Slot 0 now holds all ones: source 0 is caught by slot 1, address all-ones by slot 0.
    pending_words.push_back(table_write(CMD_WR_BL, 8'd0, 32'hFFFF_FFFF, $urandom));
    pending_words.push_back(packet_to(32'd0, 64'd1000));
    pending_words.push_back(packet_to(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF));
    // Rate limiting: 1000/s gives a 1 ms gap.
    pending_words.push_back(table_write(CMD_WR_RT, 8'd3, hosts[1], 32'd1000));
    pending_words.push_back(packet_to(hosts[1], START_NS));
    pending_words.push_back(packet_to(hosts[1], START_NS + 64'd999999));
    pending_words.push_back(packet_to(hosts[1], START_NS + 64'd1000000));
    // Several slots for one source: later slot drops after earlier passes.
    pending_words.push_back(table_write(CMD_WR_RT, 8'd7, hosts[1], 32'd1));
    pending_words.push_back(table_write(CMD_WR_RT, 8'd255, hosts[1], 32'hFFFF_FFFF));
    pending_words.push_back(packet_to(hosts[1], START_NS + 64'd3000000));
    pending_words.push_back(packet_to(hosts[1], START_NS + 64'd5000000));
    // Time going backward wraps to a huge gap.
    pending_words.push_back(packet_to(hosts[1], 64'd0));
    pending_words.push_back(table_write(CMD_WR_RT, 8'd3, hosts[1], 32'd0));
    pending_words.push_back(packet_to(hosts[1], 64'd1));
    drain_all();

    gen_clock = START_NS + 64'd10000000000;
    ports = '{16'd0, 16'hFFFF, 16'd0, DEFAULT_PORT};
    ports[2] = 16'($urandom);
    for (int p = 0; p < 4; p++) begin
      set_port(ports[p]);
      if (p == 3) calm = 1'b1;
      repeat ((p == 3) ? 350 : 260) pending_words.push_back(random_word());
      drain_all();
    end

    if (mismatches == 0 && verdicts_due.size() == 0) begin
      $display("tb_packet_blocklist_rate_filter_core: PASS");
    end else begin
      $display("tb_packet_blocklist_rate_filter_core: FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #80000000;
    $display("tb_packet_blocklist_rate_filter_core: FAIL");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/pbrf_pkg.sv
rtl/core/pbrf_ram.sv
rtl/core/pbrf_div.sv
rtl/core/packet_blocklist_rate_filter_core.sv
rtl/core/pbrf_checker.sv
test/tb_packet_blocklist_rate_filter_core.sv
